// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/llf_pkg.sv -----
package llf_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int STATE_BITS     = 32;
	localparam int COEF_FRAC_BITS = 20;
	localparam int FRAC_BITS      = SAMPLE_BITS - 1;
	localparam int ACC_BITS       = STATE_BITS + 2;
	localparam int OPND_BITS      = STATE_BITS + 1;
	localparam int PROD_BITS      = 2 * STATE_BITS;
	localparam int MAG_BITS       = PROD_BITS - COEF_FRAC_BITS;

	localparam int CP_BITS       = 21;
	localparam int CK_BITS       = 22;
	localparam int CR_BITS       = 23;
	localparam int CFG_DATA_BITS = 23;
	localparam int CFG_IDX_BITS  = 2;

	// reciprocal of 6 for magnitudes below 2^32
	localparam int                    DIV6_SHIFT = 34;
	localparam logic [STATE_BITS-1:0] DIV6_MULT  = 32'hAAAA_AAAB;

	localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEFF_P = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEFF_K = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEFF_R = 2'd3;

	localparam int                 PC_BITS  = 6;
	localparam logic [PC_BITS-1:0] PC_END   = 6'd49;
	localparam logic [PC_BITS-1:0] PC_BYP   = 6'd50;
	localparam int                 STG_BASE = 6;
	localparam int                 STG_LEN  = 7;

	typedef enum logic [1:0] {SET_NONE, SET_X, SET_C} set_t;
	typedef enum logic [2:0] {A_C, A_SIP, A_K, A_R, A_T} a_sel_t;
	typedef enum logic [1:0] {B_P, B_SO, B_C, B_D6} b_sel_t;
	typedef enum logic [1:0] {SH_COEF, SH_FRAC, SH_DIV} sh_t;
	typedef enum logic [1:0] {OP_NONE, OP_LOAD, OP_ADD, OP_SUB} op_t;
	typedef enum logic [2:0] {WB_NONE, WB_C, WB_T, WB_CSO, WB_SIP} wb_t;
	typedef enum logic [1:0] {J_NEXT, J_DIS, J_ALWAYS, J_END} jmp_t;

	typedef struct packed {
		set_t               set;
		a_sel_t             a;
		b_sel_t             b;
		logic [1:0]         idx;
		sh_t                sh;
		op_t                op;
		wb_t                wb;
		jmp_t               jmp;
		logic [PC_BITS-1:0] target;
	} uc_word_t;

	localparam uc_word_t UC_NOP = '{SET_NONE, A_C, B_P, 2'd0, SH_COEF, OP_NONE, WB_NONE,
		J_NEXT, '0};

	function automatic logic signed [STATE_BITS-1:0] sat_state(
		logic signed [ACC_BITS-1:0] v);
		logic signed [STATE_BITS-1:0] r;
		r = v[STATE_BITS-1:0];
		if (!v[ACC_BITS-1] && (|v[ACC_BITS-2:STATE_BITS-1]))
			r = {1'b0, {(STATE_BITS-1){1'b1}}};
		else if (v[ACC_BITS-1] && !(&v[ACC_BITS-2:STATE_BITS-1]))
			r = {1'b1, {(STATE_BITS-1){1'b0}}};
		return r;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] sat_sample(logic signed [STATE_BITS-1:0] v);
		logic [SAMPLE_BITS-1:0] r;
		r = v[SAMPLE_BITS-1:0];
		if (!v[STATE_BITS-1] && (|v[STATE_BITS-2:SAMPLE_BITS-1]))
			r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		else if (v[STATE_BITS-1] && !(&v[STATE_BITS-2:SAMPLE_BITS-1]))
			r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		return r;
	endfunction

	function automatic uc_word_t uc_mul(a_sel_t a, b_sel_t b, logic [1:0] idx, sh_t sh,
		op_t op);
		uc_word_t w;
		w     = UC_NOP;
		w.a   = a;
		w.b   = b;
		w.idx = idx;
		w.sh  = sh;
		w.op  = op;
		return w;
	endfunction

	function automatic uc_word_t uc_wb(wb_t wb, logic [1:0] idx);
		uc_word_t w;
		w     = UC_NOP;
		w.wb  = wb;
		w.idx = idx;
		return w;
	endfunction

	// Program: feedback subtract, four ladder stages, soft clipper, output.
	function automatic uc_word_t ucode_rom(logic [PC_BITS-1:0] pc);
		uc_word_t w;
		int       base;
		case (pc)
			6'd0: begin
				w        = UC_NOP;
				w.set    = SET_X;
				w.jmp    = J_DIS;
				w.target = PC_BYP;
			end
			6'd1:  w = uc_mul(A_R, B_SO, 2'd3, SH_COEF, OP_SUB);
			6'd5:  w = uc_wb(WB_C, 2'd0);
			6'd34: w = uc_mul(A_C, B_C, 2'd0, SH_FRAC, OP_LOAD);
			6'd38: w = uc_wb(WB_T, 2'd0);
			6'd39: w = uc_mul(A_T, B_C, 2'd0, SH_FRAC, OP_LOAD);
			6'd43: w = uc_wb(WB_T, 2'd0);
			6'd44: begin
				w     = uc_mul(A_T, B_D6, 2'd0, SH_DIV, OP_SUB);
				w.set = SET_C;
			end
			6'd48: w = uc_wb(WB_CSO, 2'd3);
			PC_END: begin
				w     = UC_NOP;
				w.jmp = J_END;
			end
			PC_BYP: begin
				w        = uc_wb(WB_C, 2'd0);
				w.jmp    = J_ALWAYS;
				w.target = PC_END;
			end
			default: w = UC_NOP;
		endcase
		for (int n = 0; n < 4; n++) begin
			base = STG_BASE + n * STG_LEN;
			if (pc == PC_BITS'(base))
				w = uc_mul(A_C, B_P, 2'(n), SH_COEF, OP_LOAD);
			if (pc == PC_BITS'(base + 1))
				w = uc_mul(A_SIP, B_P, 2'(n), SH_COEF, OP_ADD);
			if (pc == PC_BITS'(base + 2)) begin
				w    = uc_mul(A_K, B_SO, 2'(n), SH_COEF, OP_SUB);
				w.wb = WB_SIP;
			end
			if (pc == PC_BITS'(base + 6))
				w = uc_wb((n == 3) ? WB_C : WB_CSO, 2'(n));
		end
		return w;
	endfunction

endpackage

// ----- hw/rtl/llf_seq.sv -----
module llf_seq import llf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     enable,
	input  logic     out_free,
	output uc_word_t uc,
	output logic     busy,
	output logic     done
);

	logic               busy_q;
	logic [PC_BITS-1:0] pc_q;
	uc_word_t           rom;

	assign rom  = ucode_rom(pc_q);
	assign busy = busy_q;
	assign uc   = busy_q ? rom : UC_NOP;
	assign done = busy_q && (rom.jmp == J_END) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= '0;
		end else if (busy_q) begin
			case (rom.jmp)
				J_DIS:    pc_q <= enable ? pc_q + 1'b1 : rom.target;
				J_ALWAYS: pc_q <= rom.target;
				J_END: begin
					if (out_free)
						busy_q <= 1'b0;
				end
				default:  pc_q <= pc_q + 1'b1;
			endcase
		end
	end

endmodule

// ----- hw/rtl/llf_dp.sv -----
module llf_dp import llf_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  uc_word_t                     uc,
	input  logic signed [SAMPLE_BITS-1:0] x,
	input  logic [CP_BITS-1:0]           coeff_p,
	input  logic signed [CK_BITS-1:0]    coeff_k,
	input  logic [CR_BITS-1:0]           coeff_r,
	output logic signed [STATE_BITS-1:0] c
);

	logic signed [STATE_BITS-1:0] so_q  [4];
	logic signed [STATE_BITS-1:0] sip_q [4];
	logic signed [STATE_BITS-1:0] c_q;
	logic signed [STATE_BITS-1:0] t_q;
	logic signed [ACC_BITS-1:0]   acc_q;
	logic signed [STATE_BITS-1:0] acc_sat;

	logic signed [OPND_BITS-1:0] a_v;
	logic signed [OPND_BITS-1:0] b_v;
	logic [OPND_BITS-1:0]        a_abs;
	logic [OPND_BITS-1:0]        b_abs;

	logic [STATE_BITS-1:0] ma_s1;
	logic [STATE_BITS-1:0] mb_s1;
	logic                  neg_s1;
	sh_t                   sh_s1;
	op_t                   op_s1;

	logic [PROD_BITS-1:0] prod_s2;
	logic                 neg_s2;
	sh_t                  sh_s2;
	op_t                  op_s2;

	logic signed [STATE_BITS-1:0] res_s3;
	op_t                          op_s3;

	logic [PROD_BITS-1:0]         rsum;
	logic [MAG_BITS-1:0]          mag;
	logic signed [STATE_BITS-1:0] res;

	assign c       = c_q;
	assign acc_sat = sat_state(acc_q);

	always_comb begin
		case (uc.a)
			A_C:     a_v = OPND_BITS'(c_q);
			A_SIP:   a_v = OPND_BITS'(sip_q[uc.idx]);
			A_K:     a_v = OPND_BITS'(coeff_k);
			A_R:     a_v = OPND_BITS'(coeff_r);
			A_T:     a_v = OPND_BITS'(t_q);
			default: a_v = '0;
		endcase
		case (uc.b)
			B_P:     b_v = OPND_BITS'(coeff_p);
			B_SO:    b_v = OPND_BITS'(so_q[uc.idx]);
			B_C:     b_v = OPND_BITS'(c_q);
			B_D6:    b_v = OPND_BITS'(DIV6_MULT);
			default: b_v = '0;
		endcase
		a_abs = a_v[OPND_BITS-1] ? OPND_BITS'(-a_v) : OPND_BITS'(a_v);
		b_abs = b_v[OPND_BITS-1] ? OPND_BITS'(-b_v) : OPND_BITS'(b_v);
	end

	// magnitude rounding, ties away from zero (the divide shift truncates), then saturation
	always_comb begin
		rsum = prod_s2;
		case (sh_s2)
			SH_COEF: begin
				rsum = prod_s2 + (PROD_BITS'(1) << (COEF_FRAC_BITS - 1));
				mag  = MAG_BITS'(rsum >> COEF_FRAC_BITS);
			end
			SH_FRAC: begin
				rsum = prod_s2 + (PROD_BITS'(1) << (FRAC_BITS - 1));
				mag  = MAG_BITS'(rsum >> FRAC_BITS);
			end
			SH_DIV:  mag = MAG_BITS'(prod_s2 >> DIV6_SHIFT);
			default: mag = '0;
		endcase
		if (!neg_s2)
			res = (mag > MAG_BITS'({1'b0, {(STATE_BITS-1){1'b1}}})) ?
				{1'b0, {(STATE_BITS-1){1'b1}}} : STATE_BITS'(mag);
		else
			res = (mag >= MAG_BITS'({1'b1, {(STATE_BITS-1){1'b0}}})) ?
				{1'b1, {(STATE_BITS-1){1'b0}}} : -STATE_BITS'(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
			op_s2 <= OP_NONE;
			op_s3 <= OP_NONE;
		end else begin
			op_s1 <= uc.op;
			op_s2 <= op_s1;
			op_s3 <= op_s2;
		end
	end

	always_ff @(posedge clk) begin
		ma_s1   <= a_abs[STATE_BITS-1:0];
		mb_s1   <= b_abs[STATE_BITS-1:0];
		neg_s1  <= a_v[OPND_BITS-1] ^ b_v[OPND_BITS-1];
		sh_s1   <= uc.sh;
		prod_s2 <= ma_s1 * mb_s1;
		neg_s2  <= neg_s1;
		sh_s2   <= sh_s1;
		res_s3  <= res;
	end

	always_ff @(posedge clk) begin
		case (uc.set)
			SET_X: acc_q <= ACC_BITS'(x);
			SET_C: acc_q <= ACC_BITS'(c_q);
			default: begin
				case (op_s3)
					OP_LOAD: acc_q <= ACC_BITS'(res_s3);
					OP_ADD:  acc_q <= acc_q + ACC_BITS'(res_s3);
					OP_SUB:  acc_q <= acc_q - ACC_BITS'(res_s3);
					default: acc_q <= acc_q;
				endcase
			end
		endcase
		case (uc.wb)
			WB_C:    c_q <= acc_sat;
			WB_T:    t_q <= acc_sat;
			WB_CSO:  c_q <= acc_sat;
			default: c_q <= c_q;
		endcase
	end

	// ladder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				so_q[i]  <= '0;
				sip_q[i] <= '0;
			end
		end else begin
			case (uc.wb)
				WB_CSO:  so_q[uc.idx]  <= acc_sat;
				WB_SIP:  sip_q[uc.idx] <= c_q;
				default: ;
			endcase
		end
	end

endmodule

// ----- hw/rtl/ladder_lowpass_filter.sv -----
// Each accepted sample runs the 50-step microcode program when enabled, or its bypass steps
// when disabled; s_axis_tready stays low until the program ends, so one sample is in work at a time.
// The program runs all 16 multiplies through one shared 32x32 multiplier pipeline.
// A result waiting on m_axis holds the program only at its last step.
// Reset: config registers and ladder state clear to zero, sequencer idles, output empties.
`include "assert_macros.svh"

module ladder_lowpass_filter import llf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [SAMPLE_BITS-1:0]   s_axis_tdata,  // sample_in
	input  logic                     s_axis_tlast,  // block_end
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [SAMPLE_BITS-1:0]   m_axis_tdata,  // sample_out
	output logic                     m_axis_tlast,  // block_end_out
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	logic                          enable_q;
	logic [CP_BITS-1:0]            coeff_p_q;
	logic signed [CK_BITS-1:0]     coeff_k_q;
	logic [CR_BITS-1:0]            coeff_r_q;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          blk_q;
	logic                          out_valid_q;
	logic [SAMPLE_BITS-1:0]        out_data_q;
	logic                          out_last_q;

	logic                          start;
	logic                          out_free;
	logic                          seq_busy;
	logic                          seq_done;
	uc_word_t                      uc;
	logic signed [STATE_BITS-1:0]  dp_c;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !seq_busy;
	assign start         = s_axis_tvalid && !seq_busy;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			coeff_p_q <= '0;
			coeff_k_q <= '0;
			coeff_r_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLE:  enable_q  <= cfg_data[0];
				REG_COEFF_P: coeff_p_q <= cfg_data[CP_BITS-1:0];
				REG_COEFF_K: coeff_k_q <= cfg_data[CK_BITS-1:0];
				REG_COEFF_R: coeff_r_q <= cfg_data[CR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= s_axis_tdata;
			blk_q <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (seq_done)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			out_data_q <= sat_sample(dp_c);
			out_last_q <= blk_q;
		end
	end

	llf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.enable   (enable_q),
		.out_free (out_free),
		.uc       (uc),
		.busy     (seq_busy),
		.done     (seq_done)
	);

	llf_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.uc      (uc),
		.x       (x_q),
		.coeff_p (coeff_p_q),
		.coeff_k (coeff_k_q),
		.coeff_r (coeff_r_q),
		.c       (dp_c)
	);

	`ASSERT_NXT(a_one_in_work, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "new beat taken while a sample is in work")
	`ASSERT_IMP(a_done_out_free, clk, arst_n, seq_done, !m_axis_tvalid || m_axis_tready, "result overwrites a pending output beat")
	`ASSERT_IMP(a_out_from_run, clk, arst_n, $rose(m_axis_tvalid), $past(seq_busy), "output beat without a program run")

endmodule
